// ===== rtl/tfn_pkg.sv =====
// shared widths and stage payload types for the face normal pipeline
// no dependencies
`default_nettype none
package tfn_pkg;
	localparam int CW = 16;            // coordinate width
	localparam int FB = 14;            // normal fraction bits
	localparam int EW = CW + 1;        // edge width
	localparam int NW = 2 * EW + 1;    // cross product width
	localparam int MW = NW;            // magnitude width
	localparam int SHW = 6;
	localparam int QW = 31 + FB + 1;   // dividend width
	localparam int LW = 32;            // length width
	localparam int OW = 16;

	typedef struct packed {
		logic [2:0][MW-1:0] mag;
		logic [2:0]         neg;
		logic               degen;
	} mag_t;

	typedef struct packed {
		logic [2:0][30:0] m;
		logic [2:0]       neg;
		logic             degen;
	} norm_t;
endpackage
`default_nettype wire

// ===== rtl/tfn_cross.sv =====
// edges, cross product and magnitudes, two register stages
// depends on tfn_pkg
`default_nettype none
module tfn_cross (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vin,
	input  wire logic [8:0][tfn_pkg::CW-1:0] c,
	output logic                             vout,
	output tfn_pkg::mag_t                    res
);
	logic signed [2:0][tfn_pkg::EW-1:0] e0_s1, e1_s1;
	logic signed [tfn_pkg::NW-1:0] n0, n1, n2;
	logic v_s1, v_s2;
	tfn_pkg::mag_t m_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e0_s1[i] <= $signed({c[3+i][tfn_pkg::CW-1], c[3+i]})
					- $signed({c[i][tfn_pkg::CW-1], c[i]});
				e1_s1[i] <= $signed({c[6+i][tfn_pkg::CW-1], c[6+i]})
					- $signed({c[i][tfn_pkg::CW-1], c[i]});
			end
		end
	end
	// elements of a packed array are unsigned, so each is taken as signed
	always_comb begin
		n0 = tfn_pkg::NW'($signed(e0_s1[1]) * $signed(e1_s1[2]))
			- tfn_pkg::NW'($signed(e0_s1[2]) * $signed(e1_s1[1]));
		n1 = tfn_pkg::NW'($signed(e0_s1[2]) * $signed(e1_s1[0]))
			- tfn_pkg::NW'($signed(e0_s1[0]) * $signed(e1_s1[2]));
		n2 = tfn_pkg::NW'($signed(e0_s1[0]) * $signed(e1_s1[1]))
			- tfn_pkg::NW'($signed(e0_s1[1]) * $signed(e1_s1[0]));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2.neg   <= {n2[tfn_pkg::NW-1], n1[tfn_pkg::NW-1], n0[tfn_pkg::NW-1]};
			m_s2.mag[0] <= n0[tfn_pkg::NW-1] ? -n0 : n0;
			m_s2.mag[1] <= n1[tfn_pkg::NW-1] ? -n1 : n1;
			m_s2.mag[2] <= n2[tfn_pkg::NW-1] ? -n2 : n2;
			m_s2.degen <= (n0 == '0) && (n1 == '0) && (n2 == '0);
		end
	end
	assign vout = v_s2;
	assign res  = m_s2;
endmodule
`default_nettype wire

// ===== rtl/tfn_norm.sv =====
// common shift that puts the largest magnitude in [2^30, 2^31)
// depends on tfn_pkg
`default_nettype none
module tfn_norm (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vin,
	input  wire tfn_pkg::mag_t din,
	output logic               vout,
	output tfn_pkg::norm_t     res
);
	logic [tfn_pkg::MW-1:0] mx;
	logic [tfn_pkg::SHW-1:0] lead;
	logic [tfn_pkg::SHW-1:0] lead_s3;
	tfn_pkg::mag_t d_s3;
	logic v_s3, v_s4;
	tfn_pkg::norm_t n_s4;
	logic [tfn_pkg::MW+31:0] w;
	logic [2:0][30:0] sh;
	// leading one of the or of the magnitudes equals that of the max
	always_comb begin
		mx = din.mag[0] | din.mag[1] | din.mag[2];
		lead = '0;
		for (int i = 0; i < tfn_pkg::MW; i++)
			if (mx[i]) lead = tfn_pkg::SHW'(i);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= vin;
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= din;
			lead_s3 <= lead;
		end
	end
	always_comb begin
		w = '0;
		for (int i = 0; i < 3; i++) begin
			w = {d_s3.mag[i], 32'b0} >> lead_s3;
			sh[i] = w[32:2];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s4.neg   <= d_s3.neg;
			n_s4.degen <= d_s3.degen;
			n_s4.m     <= sh;
		end
	end
	assign vout = v_s4;
	assign res  = n_s4;
endmodule
`default_nettype wire

// ===== rtl/tfn_sqrt.sv =====
// sum of squares and pipelined integer square root, one result bit per stage
// depends on tfn_pkg
`default_nettype none
module tfn_sqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              vin,
	input  wire tfn_pkg::norm_t    din,
	output logic                   vout,
	output tfn_pkg::norm_t         dout,
	output logic [tfn_pkg::LW-1:0] len
);
	localparam int SW = 64;
	localparam int NS = 32;
	logic [2:0][SW-1:0] sq_s1;
	logic [SW-1:0] sum_s2;
	tfn_pkg::norm_t d_s1, d_s2;
	logic v_s1, v_s2;
	logic [NS:0] v_p;
	tfn_pkg::norm_t d_p [NS+1];
	logic [SW-1:0] rem_p [NS+1];
	logic [tfn_pkg::LW-1:0] root_p [NS+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_p[NS:1] <= '0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_p[NS:1] <= v_p[NS-1:0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= din;
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= SW'(din.m[i]) * SW'(din.m[i]);
			d_s2 <= d_s1;
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end
	assign v_p[0]    = v_s2;
	assign d_p[0]    = d_s2;
	assign rem_p[0]  = sum_s2;
	assign root_p[0] = '0;
	for (genvar k = 0; k < NS; k++) begin : g_rt
		localparam int B = NS - 1 - k;
		logic [SW-1:0] trial;
		assign trial = (SW'(root_p[k]) << (B + 1)) | (SW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				d_p[k+1] <= d_p[k];
				if (rem_p[k] >= trial) begin
					rem_p[k+1]  <= rem_p[k] - trial;
					root_p[k+1] <= root_p[k] | (tfn_pkg::LW'(1) << B);
				end else begin
					rem_p[k+1]  <= rem_p[k];
					root_p[k+1] <= root_p[k];
				end
			end
		end
	end
	assign vout = v_p[NS];
	assign dout = d_p[NS];
	assign len  = root_p[NS];
endmodule
`default_nettype wire

// ===== rtl/tfn_div.sv =====
// three pipelined restoring dividers, one quotient bit per stage, with rounding
// depends on tfn_pkg
`default_nettype none
module tfn_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      vin,
	input  wire tfn_pkg::norm_t            din,
	input  wire logic [tfn_pkg::LW-1:0]    len,
	output logic                           vout,
	output logic [2:0][tfn_pkg::OW-1:0]    nrm,
	output logic                           degen
);
	localparam int QW = tfn_pkg::QW;
	localparam int RW = tfn_pkg::LW + 1;
	logic [QW:0] v_p;
	logic [2:0] neg_p [QW+1];
	logic dg_p [QW+1];
	logic [tfn_pkg::LW-1:0] d_p [QW+1];
	logic [2:0][QW-1:0] num_p [QW+1];
	logic [2:0][RW-1:0] rem_p [QW+1];
	logic [2:0][QW-1:0] q_p [QW+1];
	logic v_o;
	logic [2:0][tfn_pkg::OW-1:0] o_q;
	logic dg_o;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p[QW:1] <= '0;
			v_o <= 1'b0;
		end else if (en) begin
			v_p[QW:1] <= v_p[QW-1:0];
			v_o <= v_p[QW];
		end
	end
	assign v_p[0]   = vin;
	assign neg_p[0] = din.neg;
	assign dg_p[0]  = din.degen;
	assign d_p[0]   = len;
	for (genvar i = 0; i < 3; i++) begin : g_in
		assign num_p[0][i] = (QW'(din.m[i]) << tfn_pkg::FB) + QW'(len >> 1);
		assign rem_p[0][i] = '0;
		assign q_p[0][i]   = '0;
	end
	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [2:0][RW-1:0] t;
		for (genvar i = 0; i < 3; i++) begin : g_l
			assign t[i] = {rem_p[k][i][RW-2:0], num_p[k][i][QW-1]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_p[k+1] <= neg_p[k];
				dg_p[k+1]  <= dg_p[k];
				d_p[k+1]   <= d_p[k];
				for (int i = 0; i < 3; i++) begin
					num_p[k+1][i] <= num_p[k][i] << 1;
					if (t[i] >= RW'(d_p[k])) begin
						rem_p[k+1][i] <= t[i] - RW'(d_p[k]);
						q_p[k+1][i]   <= {q_p[k][i][QW-2:0], 1'b1};
					end else begin
						rem_p[k+1][i] <= t[i];
						q_p[k+1][i]   <= {q_p[k][i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end
	// saturate and sign, degenerate forces zero
	always_ff @(posedge clk) begin
		if (en) begin
			dg_o <= dg_p[QW];
			for (int i = 0; i < 3; i++) begin
				if (dg_p[QW])
					o_q[i] <= '0;
				else if (q_p[QW][i] > QW'(32767))
					o_q[i] <= neg_p[QW][i] ? 16'h8000 : 16'h7fff;
				else
					o_q[i] <= neg_p[QW][i] ? -q_p[QW][i][15:0] : q_p[QW][i][15:0];
			end
		end
	end
	assign vout  = v_o;
	assign nrm   = o_q;
	assign degen = dg_o;
endmodule
`default_nettype wire

// ===== rtl/triangle_face_normal_top.sv =====
// unit face normal pipeline: cross product, shift, square root, divide
// one word accepted every cycle while the output register is empty or taken
// the whole pipeline advances when the output register is empty or taken
// reset clears all valid bits, payload registers are not reset
// depends on tfn_pkg, tfn_cross, tfn_norm, tfn_sqrt, tfn_div
`default_nettype none
module triangle_face_normal_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] first_x,
	input  wire logic [15:0] first_y,
	input  wire logic [15:0] first_z,
	input  wire logic [15:0] second_x,
	input  wire logic [15:0] second_y,
	input  wire logic [15:0] second_z,
	input  wire logic [15:0] third_x,
	input  wire logic [15:0] third_y,
	input  wire logic [15:0] third_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      normal_x,
	output logic [15:0]      normal_y,
	output logic [15:0]      normal_z,
	output logic             degenerate
);
	logic en, v2, v4, v6;
	tfn_pkg::mag_t m2;
	tfn_pkg::norm_t n4, n6;
	logic [tfn_pkg::LW-1:0] len6;
	logic [2:0][15:0] nrm;
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	tfn_cross u_cross (.clk, .arst_n, .en, .vin(in_valid && en),
		.c({third_z, third_y, third_x, second_z, second_y, second_x,
			first_z, first_y, first_x}), .vout(v2), .res(m2));
	tfn_norm u_norm (.clk, .arst_n, .en, .vin(v2), .din(m2), .vout(v4), .res(n4));
	tfn_sqrt u_sqrt (.clk, .arst_n, .en, .vin(v4), .din(n4), .vout(v6), .dout(n6),
		.len(len6));
	tfn_div u_div (.clk, .arst_n, .en, .vin(v6), .din(n6), .len(len6),
		.vout(out_valid), .nrm, .degen(degenerate));
	assign normal_x = nrm[0];
	assign normal_y = nrm[1];
	assign normal_z = nrm[2];
endmodule
`default_nettype wire

// ===== rtl/tfn_checker.sv =====
// port level checks for the face normal top, bound to it
// depends on triangle_face_normal_top
`default_nettype none
module tfn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] normal_x,
	input wire logic [15:0] normal_y,
	input wire logic [15:0] normal_z,
	input wire logic        degenerate
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(normal_x)) else $error("word changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
		else $error("degenerate not zero");
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> (normal_x != 0) || (normal_y != 0) || (normal_z != 0))
		else $error("zero normal");
endmodule
bind triangle_face_normal_top tfn_checker u_chk (.*);
`default_nettype wire

// ===== tb/triangle_face_normal_top_tb.sv =====
// testbench for triangle_face_normal_top: random and directed triangles, scoreboard check
// predicts each unit normal with a behavioral cross product, shift, isqrt and divide
// depends on tfn_pkg and triangle_face_normal_top
`default_nettype none
module triangle_face_normal_top_tb;
	typedef struct {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degen;
	} normal_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [15:0] first_x, first_y, first_z, second_x, second_y, second_z;
	logic [15:0] third_x, third_y, third_z;
	logic [15:0] normal_x, normal_y, normal_z;
	logic degenerate;

	normal_t normals_due[$];
	int err_count = 0;
	int idle_cycles = 0;
	bit sending_done;

	triangle_face_normal_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.third_x(third_x), .third_y(third_y), .third_z(third_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.degenerate(degenerate)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic normal_t face_normal(logic signed [15:0] v[9]);
		longint e0[3], e1[3], n[3];
		longint unsigned mag[3], maxm, sumsq, len, q;
		longint s;
		normal_t r;
		for (int i = 0; i < 3; i++) begin
			e0[i] = longint'(v[3+i]) - longint'(v[i]);
			e1[i] = longint'(v[6+i]) - longint'(v[i]);
		end
		n[0] = e0[1]*e1[2] - e0[2]*e1[1];
		n[1] = e0[2]*e1[0] - e0[0]*e1[2];
		n[2] = e0[0]*e1[1] - e0[1]*e1[0];
		r.degen = (n[0] == 0 && n[1] == 0 && n[2] == 0);
		if (r.degen) begin
			r.nx = 0; r.ny = 0; r.nz = 0;
			return r;
		end
		maxm = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = n[i] < 0 ? -n[i] : n[i];
			if (mag[i] > maxm) maxm = mag[i];
		end
		while (maxm >= (64'd1 << 31)) begin
			maxm >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (maxm < (64'd1 << 30)) begin
			maxm <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sumsq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
		len = int_sqrt(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << tfn_pkg::FB) + (len >> 1)) / len;
			s = n[i] < 0 ? -longint'(q) : longint'(q);
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			if (i == 0) r.nx = s[15:0];
			else if (i == 1) r.ny = s[15:0];
			else r.nz = s[15:0];
		end
		return r;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
		err_count++;
	endtask

	// sends one triangle word; gap drawn first, called at a falling edge
	task automatic send_triangle(logic signed [15:0] v[9]);
		int gap;
		gap = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		first_x <= v[0]; first_y <= v[1]; first_z <= v[2];
		second_x <= v[3]; second_y <= v[4]; second_z <= v[5];
		third_x <= v[6]; third_y <= v[7]; third_z <= v[8];
		in_valid <= 1;
		normals_due.push_back(face_normal(v));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stalls: a wait drawn for every word
	initial begin
		int gap;
		out_ready = 0;
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, 7) * ($urandom_range(0, 1) != 0);
			if (gap != 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		normal_t want;
		if (arst_n && out_valid && out_ready) begin
			if (normals_due.size() == 0) begin
				$display("mismatch: normal word with nothing expected");
				err_count++;
			end else begin
				want = normals_due.pop_front();
				if (normal_x !== want.nx) report("normal_x", normal_x, want.nx);
				if (normal_y !== want.ny) report("normal_y", normal_y, want.ny);
				if (normal_z !== want.nz) report("normal_z", normal_z, want.nz);
				if (degenerate !== want.degen)
					report("degenerate", 16'(degenerate), 16'(want.degen));
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000 && !(sending_done && normals_due.size() == 0)) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_extremes();
		logic signed [15:0] v[9];
		logic signed [15:0] ext[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		// coincident, collinear, axis-aligned triangles, then extreme corners
		v = '{default: 16'sh0}; send_triangle(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh0, 16'sh0, 16'sh0};
		send_triangle(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0};
		send_triangle(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 16'sd0};
		send_triangle(v);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0};
		send_triangle(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000};
		send_triangle(v);
		v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh8000};
		send_triangle(v);
		for (int k = 0; k < 16; k++) begin
			foreach (v[i]) v[i] = ext[$urandom_range(0, 3)];
			send_triangle(v);
		end
	endtask

	task automatic test_random(int count);
		logic signed [15:0] v[9];
		int s;
		for (int k = 0; k < count; k++) begin
			s = $urandom_range(0, 9);
			foreach (v[i]) v[i] = 16'($urandom);
			if (s == 0) begin
				// collinear: third = first + 2*(second - first) small
				for (int i = 0; i < 3; i++) begin
					v[3+i] = v[i] + $signed(16'($urandom_range(0, 200)) - 16'sd100);
					v[6+i] = v[i] + 16'sd2 * (v[3+i] - v[i]);
				end
			end else if (s < 4) begin
				// small triangles for low magnitudes and left shifts
				for (int i = 3; i < 9; i++)
					v[i] = v[i % 3] + $signed(16'($urandom_range(0, 6)) - 16'sd3);
			end
			send_triangle(v);
		end
	endtask

	initial begin
		arst_n = 0; in_valid = 0; sending_done = 0;
		{first_x, first_y, first_z, second_x, second_y, second_z} = '0;
		{third_x, third_y, third_z} = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_extremes();
		test_random(800);
		in_valid <= 0;
		sending_done = 1;
		while (normals_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_norm.sv
rtl/tfn_sqrt.sv
rtl/tfn_div.sv
rtl/triangle_face_normal_top.sv
rtl/tfn_checker.sv
tb/triangle_face_normal_top_tb.sv
